// ===== rtl/core/tssc_pkg.sv =====
`default_nettype none
package tssc_pkg;

	// Item kinds carried on s_tuser
	typedef enum logic [2:0] {
		KIND_MASK   = 3'd0,
		KIND_TPRI   = 3'd1,
		KIND_KEY    = 3'd2,
		KIND_RESULT = 3'd3,
		KIND_PACKET = 3'd4
	} kind_t;

	// Configuration register indexes
	localparam logic REG_TUPLE_COUNT = 1'b0;
	localparam logic REG_FIELD_COUNT = 1'b1;

	localparam int TUPLE_COUNT_W = 7;
	localparam int FIELD_COUNT_W = 4;
	localparam logic [FIELD_COUNT_W-1:0] FIELD_COUNT_RST = 4'd5;

	localparam int WORD_W = 32;
	localparam int PRI_W  = 16;
	localparam int ACT_W  = 16;

endpackage
`default_nettype wire

// ===== rtl/core/tuple_space_packet_classifier.sv =====
`default_nettype none
// Tuple space search classifier. Load beats (s_tuser = mask, tuple priority,
// rule key, rule result) fill the tuple and rule memories; packet beats fill
// the header buffer, and the beat for the last field starts a search that
// returns one result beat (best action, best priority, hit). A search walks the
// tuples in use in order. A tuple is skipped when its highest priority does not
// beat the best so far; else it is searched with one memory read and one compare
// per header field, all slots of the tuple compared side by side against one
// memory row, and its lowest matching slot is then picked. Input beats are held
// off during a search; load beats are taken while a result beat still waits at
// the output.
// Memories come up undefined; a per-tuple flag marks the slot valid row as
// written, so no clearing pass is needed after reset.
module tuple_space_packet_classifier
	import tssc_pkg::*;
#(
	parameter int MAX_TUPLES      = 64,
	parameter int MAX_FIELDS      = 8,
	parameter int SLOTS_PER_TUPLE = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// s_tdata: tuple_index[5:0], slot_index[9:6], field_index[12:10],
	//          word[44:13], priority_req[60:45], action[76:61], valid_req[77]
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,
	// s_tuser: kind[2:0]
	input  wire logic [2:0]  s_tuser,
	// m_tdata: best_action[15:0], best_priority[31:16], hit[32]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int TW  = (MAX_TUPLES > 1) ? $clog2(MAX_TUPLES) : 1;
	localparam int FW  = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
	localparam int SW  = (SLOTS_PER_TUPLE > 1) ? $clog2(SLOTS_PER_TUPLE) : 1;
	localparam int CW  = $clog2(MAX_TUPLES + 1);
	localparam int NW  = $clog2(MAX_FIELDS + 1);
	localparam int KAW = (MAX_TUPLES * MAX_FIELDS > 1) ?
		$clog2(MAX_TUPLES * MAX_FIELDS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_TRD, ST_TCHK, ST_FRD, ST_FCMP, ST_PICK, ST_DONE
	} state_t;

	// Configuration registers
	logic [TUPLE_COUNT_W-1:0] tuple_count_q;
	logic [FIELD_COUNT_W-1:0] field_count_q;

	// Beat fields
	logic [5:0]        t_raw;
	logic [3:0]        s_raw;
	logic [2:0]        f_raw;
	logic [WORD_W-1:0] word_in;
	logic [PRI_W-1:0]  pri_in;
	logic [ACT_W-1:0]  act_in;
	logic              valid_in;
	kind_t             kind_in;

	assign t_raw    = s_tdata[5:0];
	assign s_raw    = s_tdata[9:6];
	assign f_raw    = s_tdata[12:10];
	assign word_in  = s_tdata[44:13];
	assign pri_in   = s_tdata[60:45];
	assign act_in   = s_tdata[76:61];
	assign valid_in = s_tdata[77];
	assign kind_in  = kind_t'(s_tuser);

	logic          t_ok, s_ok, f_ok;
	logic [TW-1:0] t_a;
	logic [SW-1:0] s_a;
	logic [FW-1:0] f_a;

	assign t_ok = 32'(t_raw) < 32'(MAX_TUPLES);
	assign s_ok = 32'(s_raw) < 32'(SLOTS_PER_TUPLE);
	assign f_ok = 32'(f_raw) < 32'(MAX_FIELDS);
	assign t_a  = TW'(t_raw);
	assign s_a  = SW'(s_raw);
	assign f_a  = FW'(f_raw);

	// Effective counts, clamped to the store sizes
	logic [NW-1:0] nf_eff;
	logic [CW-1:0] nt_eff;

	always_comb begin
		if (field_count_q == '0) begin
			nf_eff = NW'(1);
		end else if (32'(field_count_q) > 32'(MAX_FIELDS)) begin
			nf_eff = NW'(MAX_FIELDS);
		end else begin
			nf_eff = NW'(field_count_q);
		end
		if (32'(tuple_count_q) > 32'(MAX_TUPLES)) begin
			nt_eff = CW'(MAX_TUPLES);
		end else begin
			nt_eff = CW'(tuple_count_q);
		end
	end

	state_t state_q;
	logic   in_beat;

	assign s_tready = (state_q == ST_IDLE);
	assign in_beat  = s_tvalid && s_tready;

	logic wr_mask, wr_tpri, wr_key, wr_res, wr_pkt, start;

	assign wr_mask = in_beat && kind_in == KIND_MASK && t_ok && f_ok;
	assign wr_tpri = in_beat && kind_in == KIND_TPRI && t_ok;
	assign wr_key  = in_beat && kind_in == KIND_KEY && t_ok && s_ok && f_ok;
	assign wr_res  = in_beat && kind_in == KIND_RESULT && t_ok && s_ok;
	assign wr_pkt  = in_beat && kind_in == KIND_PACKET && f_ok;
	assign start   = wr_pkt && (32'(f_raw) == 32'(nf_eff) - 32'd1);

	// Search counters
	logic [CW-1:0]              tup_q;
	logic [FW-1:0]              fld_q;
	logic [SLOTS_PER_TUPLE-1:0] match_q;
	logic [PRI_W-1:0]           best_pri_q;
	logic [ACT_W-1:0]           best_act_q;
	logic [TW-1:0]              ta;
	logic [KAW-1:0]             wr_kaddr, rd_kaddr;

	assign ta       = tup_q[TW-1:0];
	assign wr_kaddr = KAW'(32'(t_a) * MAX_FIELDS + 32'(f_a));
	assign rd_kaddr = KAW'(32'(ta) * MAX_FIELDS + 32'(fld_q));

	// Memories
	logic [WORD_W-1:0]                      mask_mem [MAX_TUPLES*MAX_FIELDS];
	logic [SLOTS_PER_TUPLE-1:0][WORD_W-1:0] key_mem  [MAX_TUPLES*MAX_FIELDS];
	logic [PRI_W-1:0]                       tpri_mem [MAX_TUPLES];
	logic [SLOTS_PER_TUPLE-1:0][WORD_W-1:0] res_mem  [MAX_TUPLES];
	logic [SLOTS_PER_TUPLE-1:0]             vld_mem  [MAX_TUPLES];
	logic [WORD_W-1:0]                      pkt_q    [MAX_FIELDS];
	logic [MAX_TUPLES-1:0]                  vinit_q;

	logic [WORD_W-1:0]                      mask_rd_q;
	logic [SLOTS_PER_TUPLE-1:0][WORD_W-1:0] key_rd_q;
	logic [PRI_W-1:0]                       tpri_rd_q;
	logic [SLOTS_PER_TUPLE-1:0][WORD_W-1:0] res_rd_q;
	logic [SLOTS_PER_TUPLE-1:0]             vld_rd_q;
	logic                                   vinit_rd_q;

	always_ff @(posedge clk) begin
		if (wr_mask) begin
			mask_mem[wr_kaddr] <= word_in;
		end
		if (wr_key) begin
			key_mem[wr_kaddr][s_a] <= word_in;
		end
		if (wr_tpri) begin
			tpri_mem[t_a] <= pri_in;
		end
		if (wr_res) begin
			res_mem[t_a][s_a] <= {pri_in, act_in};
			// Fill the whole row on its first write so no stale bit survives
			if (vinit_q[t_a]) begin
				vld_mem[t_a][s_a] <= valid_in;
			end else begin
				vld_mem[t_a] <= SLOTS_PER_TUPLE'(valid_in) << s_a;
			end
		end
		if (wr_pkt) begin
			pkt_q[f_a] <= word_in;
		end
		if (state_q == ST_TRD) begin
			tpri_rd_q  <= tpri_mem[ta];
			res_rd_q   <= res_mem[ta];
			vld_rd_q   <= vld_mem[ta];
			vinit_rd_q <= vinit_q[ta];
		end
		if (state_q == ST_FRD) begin
			key_rd_q  <= key_mem[rd_kaddr];
			mask_rd_q <= mask_mem[rd_kaddr];
		end
	end

	// Field compare across all slots of the tuple
	logic [WORD_W-1:0]          masked_pkt;
	logic [SLOTS_PER_TUPLE-1:0] field_eq;

	assign masked_pkt = pkt_q[fld_q] & mask_rd_q;

	always_comb begin
		for (int s = 0; s < SLOTS_PER_TUPLE; s++) begin
			field_eq[s] = (key_rd_q[s] == masked_pkt);
		end
	end

	// Lowest matching slot
	logic             pick_hit;
	logic [PRI_W-1:0] pick_pri;
	logic [ACT_W-1:0] pick_act;

	always_comb begin
		pick_hit = 1'b0;
		pick_pri = '0;
		pick_act = '0;
		for (int s = SLOTS_PER_TUPLE - 1; s >= 0; s--) begin
			if (match_q[s]) begin
				pick_hit = 1'b1;
				pick_pri = res_rd_q[s][31:16];
				pick_act = res_rd_q[s][15:0];
			end
		end
	end

	logic        out_valid_q;
	logic [39:0] out_data_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tup_q       <= '0;
			fld_q       <= '0;
			match_q     <= '0;
			best_pri_q  <= '0;
			best_act_q  <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			vinit_q     <= '0;
		end else begin
			if (wr_res) begin
				vinit_q[t_a] <= 1'b1;
			end
			// Drop the result beat once taken, unless a new one replaces it
			if (out_valid_q && m_tready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						tup_q      <= '0;
						best_pri_q <= '0;
						best_act_q <= '0;
						state_q    <= ST_TRD;
					end
				end
				ST_TRD: begin
					// Memory reads for the tuple are issued here
					if (tup_q == nt_eff) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_TCHK;
					end
				end
				ST_TCHK: begin
					if (tpri_rd_q > best_pri_q) begin
						fld_q   <= '0;
						match_q <= vinit_rd_q ? vld_rd_q : '0;
						state_q <= ST_FRD;
					end else begin
						tup_q   <= tup_q + CW'(1);
						state_q <= ST_TRD;
					end
				end
				ST_FRD: begin
					state_q <= ST_FCMP;
				end
				ST_FCMP: begin
					match_q <= match_q & field_eq;
					if (32'(fld_q) == 32'(nf_eff) - 32'd1) begin
						state_q <= ST_PICK;
					end else begin
						fld_q   <= fld_q + FW'(1);
						state_q <= ST_FRD;
					end
				end
				ST_PICK: begin
					if (pick_hit && pick_pri > best_pri_q) begin
						best_pri_q <= pick_pri;
						best_act_q <= pick_act;
					end
					tup_q   <= tup_q + CW'(1);
					state_q <= ST_TRD;
				end
				ST_DONE: begin
					// Hold until the output register is free
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {7'd0, best_pri_q != '0, best_pri_q, best_act_q};
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Configuration port
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tuple_count_q <= '0;
			field_count_q <= FIELD_COUNT_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_TUPLE_COUNT) begin
				tuple_count_q <= pwdata[TUPLE_COUNT_W-1:0];
			end else begin
				field_count_q <= pwdata[FIELD_COUNT_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_TUPLE_COUNT) begin
			prdata = 32'(tuple_count_q);
		end else begin
			prdata = 32'(field_count_q);
		end
	end

	// A result beat appears only when a search finishes
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result beat raised outside search end");

	// Hit flag agrees with the chosen priority
	a_hit_pri: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q[32] == (out_data_q[31:16] != '0)))
		else $error("hit flag disagrees with priority");

	// Best priority never falls during a search
	a_best_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && $past(state_q) != ST_IDLE) |->
		best_pri_q >= $past(best_pri_q))
		else $error("best priority decreased");

	// Field walk stays within the configured fields
	a_fld_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FCMP) |-> 32'(fld_q) < 32'(nf_eff))
		else $error("field counter out of range");

endmodule
`default_nettype wire

// ===== tb/tuple_space_packet_classifier_checker.sv =====
`timescale 1ns / 100ps
module tuple_space_packet_classifier_checker
	import tssc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [79:0] s_tdata,
	input  wire logic [2:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [39:0] m_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               fail_count,
	output int               pending
);

	localparam int NT = 64;
	localparam int NF = 8;
	localparam int NS = 16;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic [PRI_W-1:0] pri;
		logic             hit;
	} verdict_t;

	logic [WORD_W-1:0]        masks [NT*NF];
	logic [PRI_W-1:0]         tuple_pri [NT];
	logic [WORD_W-1:0]        keys [NT*NS*NF];
	logic [31:0]              rule_res [NT*NS];
	logic                     slot_ok [NT*NS];
	logic [WORD_W-1:0]        pkt [NF];
	logic [TUPLE_COUNT_W-1:0] n_tuples;
	logic [FIELD_COUNT_W-1:0] n_fields;
	verdict_t                 awaited [$];

	function automatic int fields_used();
		if (n_fields == 0) return 1;
		if (n_fields > NF) return NF;
		return n_fields;
	endfunction

	// Walk tuples in order, skip those that cannot beat the best, first hit per tuple
	function automatic verdict_t search();
		verdict_t v;
		int nt;
		int slot;
		bit same;
		v = '0;
		nt = (n_tuples > NT) ? NT : n_tuples;
		for (int t = 0; t < nt; t++) begin
			if (tuple_pri[t] <= v.pri) continue;
			for (int s = 0; s < NS; s++) begin
				slot = t * NS + s;
				if (!slot_ok[slot]) continue;
				same = 1;
				for (int f = 0; f < fields_used(); f++)
					if ((pkt[f] & masks[t*NF+f]) != keys[slot*NF+f]) same = 0;
				if (same) begin
					if (rule_res[slot][31:16] > v.pri) begin
						v.pri = rule_res[slot][31:16];
						v.act = rule_res[slot][15:0];
					end
					break;
				end
			end
		end
		v.hit = (v.pri != 0);
		return v;
	endfunction

	assign pending = awaited.size();

	always @(posedge clk or negedge arst_n) begin
		logic [5:0]  t;
		logic [3:0]  s;
		logic [2:0]  f;
		logic [31:0] w;
		verdict_t    exp_v;
		verdict_t    got;
		if (!arst_n) begin
			for (int i = 0; i < NT*NS; i++) slot_ok[i] = 0;
			n_tuples = '0;
			n_fields = FIELD_COUNT_RST;
			awaited.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_TUPLE_COUNT) n_tuples = pwdata[TUPLE_COUNT_W-1:0];
				else n_fields = pwdata[FIELD_COUNT_W-1:0];
			end
			if (m_tvalid && m_tready) begin
				got = '{act: m_tdata[15:0], pri: m_tdata[31:16], hit: m_tdata[32]};
				if (awaited.size() == 0) begin
					$error("unexpected result beat %h", m_tdata);
					fail_count++;
				end else begin
					exp_v = awaited.pop_front();
					if (got.act !== exp_v.act) begin
						$error("best_action exp %h got %h", exp_v.act, got.act);
						fail_count++;
					end
					if (got.pri !== exp_v.pri) begin
						$error("best_priority exp %h got %h", exp_v.pri, got.pri);
						fail_count++;
					end
					if (got.hit !== exp_v.hit) begin
						$error("hit exp %b got %b", exp_v.hit, got.hit);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				t = s_tdata[5:0];
				s = s_tdata[9:6];
				f = s_tdata[12:10];
				w = s_tdata[44:13];
				case (s_tuser)
					KIND_MASK:   masks[t*NF+f] = w;
					KIND_TPRI:   tuple_pri[t] = s_tdata[60:45];
					KIND_KEY:    keys[(t*NS+s)*NF+f] = w;
					KIND_RESULT: begin
						rule_res[t*NS+s] = {s_tdata[60:45], s_tdata[76:61]};
						slot_ok[t*NS+s] = s_tdata[77];
					end
					KIND_PACKET: begin
						pkt[f] = w;
						if (f == fields_used() - 1) awaited.push_back(search());
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== tb/tuple_space_packet_classifier_tb.sv =====
`timescale 1ns / 100ps
module tuple_space_packet_classifier_tb;
	import tssc_pkg::*;

	// kinds above the packet word carry no meaning and must be dropped
	localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
	localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
	localparam int NT = 64;
	localparam int NF = 8;
	localparam int NS = 16;
	localparam int CYCLE_LIMIT = 8000000;
	// longest search: 64 searched tuples of 8 fields
	localparam int SEARCH_CYCLES = 2 + NT * (3 + 2 * NF);

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;   // tuple[5:0] slot[9:6] field[12:10] word[44:13]
	                        // priority[60:45] action[76:61] valid[77], zero pad
	logic [2:0]  s_tuser;   // kind[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // best_action[15:0] best_priority[31:16] hit[32]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending;
	int beats_sent;
	int cycles;
	bit calm;        // no idling on either side while set
	bit stall_out;   // long receiver hold-off

	// stimulus-side shadows, used only to build matching packets and safe rules
	logic [31:0] mask_sh [NT*NF];
	logic [31:0] key_sh [NT*NS*NF];
	logic [7:0]  key_full [NT*NS];
	int          cur_fields;

	tuple_space_packet_classifier uut (.*);

	tuple_space_packet_classifier_checker chk (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[tuple_space_packet_classifier] ERROR");
			$finish;
		end
	end

	// receiver: random stalls, none while calm, all-stop during the hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= !stall_out && (calm || $urandom_range(99) >= 11);
		end
	end

	// hold the output off long enough for the input side to back up
	initial begin
		stall_out = 0;
		wait (beats_sent >= 900);
		@(posedge clk);
		stall_out = 1;
		repeat (4000) @(posedge clk);
		stall_out = 0;
	end

	task automatic send(input logic [2:0] k, input int t, input int s,
			input int f, input logic [31:0] w, input int pri,
			input int act, input int v);
		if (!calm && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {2'b00, 1'(v), 16'(act), 16'(pri), w, 3'(f), 4'(s), 6'(t)};
		do @(posedge clk); while (!s_tready);
		beats_sent++;
		case (k)
			KIND_MASK: mask_sh[t*NF+f] = w;
			KIND_KEY: begin
				key_sh[(t*NS+s)*NF+f] = w;
				key_full[t*NS+s][f] = 1'b1;
			end
			default: ;
		endcase
	endtask

	task automatic set_reg(input logic idx, input logic [31:0] val);
		// drain: let the last beat land in the checker, then wait for results
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		if (idx == REG_FIELD_COUNT)
			cur_fields = (val[3:0] == 0) ? 1 : (val[3:0] > NF) ? NF : val[3:0];
	endtask

	// write every key word first so a valid slot never exposes stale memory
	task automatic load_rule(input int t, input int s, input logic [15:0] pri,
			input logic [15:0] act, input logic v);
		for (int f = 0; f < NF; f++)
			send(KIND_KEY, t, s, f, $urandom() & mask_sh[t*NF+f], 0, 0, 0);
		send(KIND_RESULT, t, s, 0, $urandom(), pri, act, v);
	endtask

	// packet aimed at one slot's key (random bits outside the mask), or fully random
	task automatic send_packet(input int t, input int s, input bit aim);
		logic [31:0] w;
		for (int f = 0; f < cur_fields; f++) begin
			w = $urandom();
			if (aim) w = key_sh[(t*NS+s)*NF+f] | (w & ~mask_sh[t*NF+f]);
			send(KIND_PACKET, 0, 0, f, w, $urandom(), $urandom(), $urandom_range(1));
		end
	endtask

	function automatic logic [15:0] pick_pri();
		case ($urandom_range(9))
			0: return 16'hFFFF;
			1: return 16'h0000;
			2: return 16'($urandom());
			default: return 16'($urandom_range(1, 40));
		endcase
	endfunction

	task automatic noise_beat();
		logic [2:0] k;
		logic [5:0] t;
		logic [3:0] s;
		logic       v;
		k = 3'($urandom_range(KIND_UNUSED_HI));
		t = 6'($urandom());
		s = 4'($urandom());
		v = 1'($urandom_range(1));
		// never validate a slot whose keys are incomplete
		if (k == KIND_RESULT && key_full[t*NS+s] != 8'hFF) v = 1'b0;
		if (k == KIND_MASK || k == KIND_KEY) begin
			send(k, t, s, $urandom_range(NF - 1), $urandom(), $urandom(), $urandom(), v);
		end else begin
			send(k, t, s, $urandom_range(NF - 1), $urandom(), pick_pri(), $urandom(), v);
		end
	endtask

	task automatic random_phase(input logic [6:0] tc, input logic [3:0] fc, input int n);
		int start;
		int t;
		int s;
		int lim;
		set_reg(REG_TUPLE_COUNT, tc);
		set_reg(REG_FIELD_COUNT, fc);
		lim = (tc == 0) ? NT : ((tc > NT) ? NT : tc);
		start = beats_sent;
		while (beats_sent - start < n) begin
			t = $urandom_range(lim - 1);
			s = $urandom_range(NS - 1);
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6, 7: begin
					if ($urandom_range(3) == 0)
						send(KIND_TPRI, t, 0, 0, $urandom(), pick_pri(), 0, 0);
					load_rule(t, s, pick_pri(), $urandom(), $urandom_range(7) != 0);
				end
				8, 9, 10, 11, 12, 13, 14, 15:
					send_packet(t, s, key_full[t*NS+s] == 8'hFF && $urandom_range(4) != 0);
				default: noise_beat();
			endcase
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = KIND_MASK;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		cycles     = 0;
		beats_sent = 0;
		calm       = 0;
		cur_fields = FIELD_COUNT_RST;
		for (int i = 0; i < NT*NS; i++) key_full[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill tuple priorities, masks and the packet buffer so no search reads
		// memory that was never written
		calm = 1;
		for (int t = 0; t < NT; t++) begin
			send(KIND_TPRI, t, 0, 0, 0, $urandom_range(1, 40), 0, 0);
			for (int f = 0; f < NF; f++)
				case ($urandom_range(3))
					0: send(KIND_MASK, t, 0, f, 32'hFFFF_FFFF, 0, 0, 0);
					1: send(KIND_MASK, t, 0, f, 32'h0, 0, 0, 0);
					2: send(KIND_MASK, t, 0, f, 32'hFFFF_0000, 0, 0, 0);
					default: send(KIND_MASK, t, 0, f, $urandom(), 0, 0, 0);
				endcase
		end
		for (int f = 0; f < NF; f++) send(KIND_PACKET, 0, 0, f, $urandom(), 0, 0, 0);
		calm = 0;

		// directed: unused kinds with every bit set
		for (int k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++)
			send(3'(k), '1, '1, '1, '1, '1, '1, 1);
		set_reg(REG_TUPLE_COUNT, 4);
		set_reg(REG_FIELD_COUNT, NF);
		// tuple 2 masks nothing: every valid slot matches, lowest slot wins
		for (int f = 0; f < NF; f++) send(KIND_MASK, 2, 0, f, 32'h0, 0, 0, 0);
		send(KIND_TPRI, 2, 0, 0, 0, 16'hFFFF, 0, 0);
		load_rule(2, 5, 7, 16'hAAAA, 1);
		load_rule(2, 9, 16'hFFFF, 16'hFFFF, 1);
		// tuple 3 can never beat anything: skipped
		send(KIND_TPRI, 3, 0, 0, 0, 16'h0000, 0, 0);
		load_rule(3, 0, 16'hFFFF, 16'h1234, 1);
		send_packet(2, 5, 1);
		// rule priority 0 never counts as a hit
		load_rule(2, 5, 0, 16'h5555, 1);
		send_packet(2, 5, 1);
		// no tuples in use: empty result
		set_reg(REG_TUPLE_COUNT, 0);
		send_packet(0, 0, 0);

		// random: sweep settings, extremes and out-of-range values included
		random_phase(7'd8, 4'd5, 100);
		calm = 1;
		random_phase(7'd3, 4'd1, 70);
		calm = 0;
		random_phase(7'd127, 4'd0, 70);
		random_phase(7'd16, 4'd15, 120);
		random_phase(7'd64, 4'd8, 50);
		random_phase(7'd6, 4'd3, 120);
		random_phase(7'd2, 4'd2, 50);

		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SEARCH_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("[tuple_space_packet_classifier] OK");
		end else begin
			$display("[tuple_space_packet_classifier] ERROR");
		end
		$finish;
	end

endmodule
